### rtl/core/ipacl_pkg.sv
// Shared types, constants and mask functions of the sender access list.
package ipacl_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 16;
    localparam int TOTAL_W = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ADJUSTED = 2'd2;

    localparam logic [31:0] V4_MAPPED_TAG = 32'h0000ffff;

    // States of the back part's table engine.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CMP
    } bk_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic        family;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  prefix_length;
        logic [31:0] scope_id;
    } in_item_t;

    typedef struct packed {
        logic                 allowed;
        logic [1:0]           status;
        logic [TOTAL_W-1:0]   entry_total;
    } out_item_t;

    // Classified command passed from the front part to the back part.
    typedef struct packed {
        cmd_t        command;
        logic        family;
        logic        adjusted;
        logic        mapped;
        logic [63:0] net_high;
        logic [63:0] net_low;
        logic [7:0]  prefix;
        logic [31:0] scope;
    } work_t;

    typedef struct packed {
        logic        family;
        logic [63:0] net_high;
        logic [63:0] net_low;
        logic [7:0]  prefix;
        logic [31:0] scope;
    } entry_t;

    function automatic logic [31:0] mask_v4(input logic [7:0] bits);
        logic [31:0] m;
        m = '0;
        for (int i = 0; i < 32; i++) begin
            m[31-i] = (32'(i) < 32'(bits));
        end
        return m;
    endfunction

    function automatic logic [127:0] mask_v6(input logic [7:0] bits);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 128; i++) begin
            m[127-i] = (32'(i) < 32'(bits));
        end
        return m;
    endfunction

endpackage

### rtl/core/ip_prefix_sender_acl_core.sv
// Top level of the sender access list: front classifier, queue and table engine.
// Clear, add, an unknown command, or a check on an empty table: the item is registered
// in the queue, then its result is registered once the result register is free.
// A check scans the table one entry at a time up to the first hit, a read and a compare
// state per entry, set by the single registered read port of the table memory.
// Reset empties the table, queue and result register at once; contents stay unwritten.
module ip_prefix_sender_acl_core #(
    parameter int TABLE_ENTRIES = ipacl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ipacl_pkg::in_item_t  in_item,
    output logic                 full,
    input  logic                 pop,
    output ipacl_pkg::out_item_t out_item,
    output logic                 empty
);

    ipacl_pkg::work_t front_work, queue_work;
    logic             q_empty, q_pop;

    ipacl_front u_front (
        .item (in_item),
        .work (front_work)
    );

    ipacl_queue #(
        .DEPTH (ipacl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_work),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (queue_work),
        .empty     (q_empty)
    );

    ipacl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (queue_work),
        .work_valid (!q_empty),
        .work_pop   (q_pop),
        .result     (out_item),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

### rtl/core/ipacl_front.sv
// Front part: checks and masks an item's prefix and classifies the sender.
module ipacl_front (
    input  ipacl_pkg::in_item_t item,
    output ipacl_pkg::work_t    work
);

    logic        bad_len;
    logic [7:0]  plen;
    logic [127:0] m6;
    logic [31:0] m4;

    always_comb
    begin
        if (item.family == 1'b0) begin
            bad_len = (item.prefix_length == 8'd0) || (item.prefix_length > 8'd32);
            plen = bad_len ? 8'd32 : item.prefix_length;
        end else begin
            bad_len = (item.prefix_length == 8'd0) || (item.prefix_length > 8'd128);
            plen = bad_len ? 8'd128 : item.prefix_length;
        end
        m4 = ipacl_pkg::mask_v4(plen);
        m6 = ipacl_pkg::mask_v6(plen);
        work.command  = ipacl_pkg::cmd_t'(item.command);
        work.family   = item.family;
        work.adjusted = bad_len;
        work.prefix   = plen;
        work.mapped   = (item.address_high == 64'd0) &&
                        (item.address_low[63:32] == ipacl_pkg::V4_MAPPED_TAG);
        // Only an add uses the masked form; a check keeps the raw sender.
        if (work.command == ipacl_pkg::CMD_ADD) begin
            if (item.family == 1'b0) begin
                work.net_high = 64'd0;
                work.net_low  = {32'd0, item.address_low[31:0] & m4};
                work.scope    = 32'd0;
            end else begin
                work.net_high = item.address_high & m6[127:64];
                work.net_low  = item.address_low & m6[63:0];
                work.scope    = item.scope_id;
            end
        end else begin
            work.net_high = item.address_high;
            work.net_low  = item.address_low;
            work.scope    = item.scope_id;
        end
    end

endmodule

### rtl/core/ipacl_queue.sv
// Short queue of classified items between the front and back parts.
module ipacl_queue #(
    parameter int DEPTH = ipacl_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipacl_pkg::work_t  push_data,
    output logic              full,
    input  logic              pop,
    output ipacl_pkg::work_t  pop_data,
    output logic              empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ipacl_pkg::work_t      slot_reg [DEPTH];
    logic [IW-1:0]         wr_reg, wr_next, rd_reg, rd_next;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign full     = (cnt_reg == ($clog2(DEPTH+1))'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == IW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == IW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/ipacl_back.sv
// Back part: table storage, sequential scan for checks, and the result register.
module ipacl_back #(
    parameter int TABLE_ENTRIES = ipacl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ipacl_pkg::work_t    work,
    input  logic                work_valid,
    output logic                work_pop,
    output ipacl_pkg::out_item_t result,
    output logic                empty,
    input  logic                pop
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(ipacl_pkg::entry_t);

    ipacl_pkg::bk_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 res_valid_reg, res_valid_next;
    ipacl_pkg::out_item_t res_reg, res_next;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    ipacl_pkg::entry_t    wentry, rentry;
    logic [EW-1:0]        rdata;
    logic                 hit;
    logic [31:0]          m4;
    logic [127:0]         m6;
    logic                 out_free;

    assign wentry.family   = work.family;
    assign wentry.net_high = work.net_high;
    assign wentry.net_low  = work.net_low;
    assign wentry.prefix   = work.prefix;
    assign wentry.scope    = work.scope;
    assign waddr           = count_reg[AW-1:0];
    assign raddr           = idx_reg[AW-1:0];
    assign rentry          = ipacl_pkg::entry_t'(rdata);

    ipacl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        m4 = ipacl_pkg::mask_v4(rentry.prefix);
        m6 = ipacl_pkg::mask_v6(rentry.prefix);
        hit = 1'b0;
        if (work.family == 1'b0) begin
            hit = !rentry.family &&
                  ((work.net_low[31:0] & m4) == rentry.net_low[31:0]);
        end else if (rentry.family) begin
            hit = ((work.net_high & m6[127:64]) == rentry.net_high) &&
                  ((work.net_low & m6[63:0]) == rentry.net_low) &&
                  ((rentry.scope == 32'd0) || (work.scope == rentry.scope));
        end else begin
            hit = work.mapped &&
                  ((work.net_low[31:0] & m4) == rentry.net_low[31:0]);
        end
    end

    assign empty    = !res_valid_reg;
    assign out_free = !res_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        we             = 1'b0;
        work_pop       = 1'b0;
        case (state_reg)
            ipacl_pkg::BK_IDLE:
            begin
                if (work_valid && out_free) begin
                    res_next.allowed = 1'b0;
                    res_next.status  = ipacl_pkg::ST_OK;
                    case (work.command)
                        ipacl_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ipacl_pkg::CMD_ADD:
                        begin
                            if (count_reg == CW'(TABLE_ENTRIES)) begin
                                res_next.status = ipacl_pkg::ST_FULL;
                            end else begin
                                we = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (work.adjusted) begin
                                    res_next.status = ipacl_pkg::ST_ADJUSTED;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if ((work.command == ipacl_pkg::CMD_CHECK) && (count_reg != '0)) begin
                        idx_next   = '0;
                        state_next = ipacl_pkg::BK_READ;
                    end else begin
                        if (work.command == ipacl_pkg::CMD_CHECK) begin
                            res_next.allowed = 1'b1;
                        end
                        res_next.entry_total = ipacl_pkg::TOTAL_W'(count_next);
                        res_valid_next = 1'b1;
                        work_pop = 1'b1;
                    end
                end
            end
            ipacl_pkg::BK_READ:
            begin
                state_next = ipacl_pkg::BK_CMP;
            end
            ipacl_pkg::BK_CMP:
            begin
                // Output register was free when the scan started and nothing else fills it.
                if (hit || (idx_reg + 1'b1 == count_reg)) begin
                    res_next.allowed     = hit;
                    res_next.status      = ipacl_pkg::ST_OK;
                    res_next.entry_total = ipacl_pkg::TOTAL_W'(count_reg);
                    res_valid_next       = 1'b1;
                    work_pop             = 1'b1;
                    state_next           = ipacl_pkg::BK_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ipacl_pkg::BK_READ;
                end
            end
            default:
            begin
                state_next = ipacl_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ipacl_pkg::BK_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

### rtl/core/ipacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ipacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
